// ===== hdl/crc_checked_command_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command deframer
// Shared shorthand for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_COMMAND_DEFRAMER_MACROS_SVH
`define CRC_CHECKED_COMMAND_DEFRAMER_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ccd_pkg.sv =====
// ----------------------------------------------------------------------------
// Command deframer package
// Types, constants and the CRC-16 byte update shared by the deframer files.
// ----------------------------------------------------------------------------
package ccd_pkg;

  // Number of 16-bit argument slots and the largest payload that fits them.
  localparam int unsigned ARG_SLOTS      = 29;
  localparam int unsigned MAX_PAYLOAD    = 2 * ARG_SLOTS;
  localparam int unsigned FRAME_OVERHEAD = 6;
  localparam int unsigned ARG_IDX_W      = 5;
  // Byte position within a frame never exceeds the longest payload plus five.
  localparam int unsigned POS_W          = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] HEADER_RESET = 8'hAA;

  typedef enum logic [1:0] {
    FS_GOOD    = 2'd0,
    FS_CRC_ERR = 2'd1,
    FS_ODD_LEN = 2'd2
  } frame_status_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_SHOW
  } ccd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          accept;
    logic          load_single;
    frame_status_e single_status;
    logic          start_args;
    logic          rd_en;
    logic          load_arg;
  } ccd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_pending;
    logic crc_ok;
    logic odd_len;
    logic no_args;
    logic out_full;
    logic last_arg;
  } ccd_status_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/ccd_rx_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received byte per request.
// ----------------------------------------------------------------------------
interface ccd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/ccd_res_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries one decoded result per request.
// ----------------------------------------------------------------------------
interface ccd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [15:0] command_code;
  logic [4:0]  argument_count;
  logic [4:0]  argument_index;
  logic [15:0] argument_value;
  logic        argument_valid;
  logic        last_of_frame;

  modport source (output valid, output frame_status, output command_code,
                  output argument_count, output argument_index, output argument_value,
                  output argument_valid, output last_of_frame, input ready);
  modport sink   (input valid, input frame_status, input command_code,
                  input argument_count, input argument_index, input argument_value,
                  input argument_valid, input last_of_frame, output ready);
endinterface

// ===== hdl/ccd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ccd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 29
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ccd_datapath.sv =====
// ----------------------------------------------------------------------------
// Command deframer datapath
// Frame parsing registers, running CRC, argument store and result register.
// ----------------------------------------------------------------------------
module ccd_datapath #(
  parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                out_ready_i,
  input  ccd_pkg::ccd_cmd_t   cmd_i,
  output ccd_pkg::ccd_status_t status_o,
  output logic                out_valid_o,
  output logic [1:0]          frame_status_o,
  output logic [15:0]         command_code_o,
  output logic [4:0]          argument_count_o,
  output logic [4:0]          argument_index_o,
  output logic [15:0]         argument_value_o,
  output logic                argument_valid_o,
  output logic                last_of_frame_o
);

  localparam int unsigned PW = ccd_pkg::POS_W;
  localparam int unsigned AW = ccd_pkg::ARG_IDX_W;

  // Frame parsing state.
  logic [7:0]    header_q;
  logic          in_frame_q, in_frame_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    len_q, len_d;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   cmd_q, cmd_d;
  logic [7:0]    check_hi_q, check_hi_d;
  logic [7:0]    pend_q, pend_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;

  // Result register.
  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;
  logic [15:0]   ocmd_q, ocmd_d;
  logic [AW-1:0] ocnt_q, ocnt_d;
  logic [AW-1:0] oidx_q, oidx_d;
  logic [15:0]   oval_q, oval_d;
  logic          oargv_q, oargv_d;
  logic          olast_q, olast_d;

  logic          active;
  logic [PW-1:0] p;
  logic [PW-1:0] off;
  logic [8:0]    pos_ext;
  logic [8:0]    len_ext;
  logic          in_body;
  logic          is_check_hi;
  logic          too_long;
  logic [15:0]   crc_base;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_rdata;

  // Position of the current byte; a header byte while hunting is position zero.
  assign active  = in_frame_q || (rx_byte_i == header_q);
  assign p       = in_frame_q ? pos_q : '0;
  assign pos_ext = {{(9 - PW){1'b0}}, p};
  assign len_ext = in_frame_q ? {1'b0, len_q} : 9'd0;
  assign in_body     = pos_ext < (len_ext + 9'd4);
  assign is_check_hi = pos_ext == (len_ext + 9'd4);
  assign crc_base    = in_frame_q ? crc_q : ccd_pkg::CRC_INIT;
  assign off         = p - PW'(4);
  assign ram_waddr   = off[AW:1];
  assign too_long = (({2'b00, rx_byte_i} + 10'(ccd_pkg::FRAME_OVERHEAD))
                     > 10'(FRAME_BUFFER_BYTES))
                    || ({1'b0, rx_byte_i} > 9'(ccd_pkg::MAX_PAYLOAD));

  // Status towards the controller.
  always_comb begin
    status_o.final_pending = in_frame_q
                             && ({{(9 - PW){1'b0}}, pos_q} == ({1'b0, len_q} + 9'd5));
    status_o.crc_ok   = crc_q == {check_hi_q, rx_byte_i};
    status_o.odd_len  = len_q[0];
    status_o.no_args  = len_q == 8'd0;
    status_o.out_full = out_valid_q;
    status_o.last_arg = idx_q == (cnt_q - AW'(1));
  end

  // Byte-by-byte frame parsing.
  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    len_d      = len_q;
    crc_d      = crc_q;
    cmd_d      = cmd_q;
    check_hi_d = check_hi_q;
    pend_d     = pend_q;
    ram_we     = 1'b0;
    if (cmd_i.accept && active) begin
      in_frame_d = 1'b1;
      pos_d      = p + PW'(1);
      if (in_body) begin
        crc_d = ccd_pkg::crc_feed(crc_base, rx_byte_i);
      end
      if (p == PW'(0)) begin
        crc_d = ccd_pkg::crc_feed(ccd_pkg::CRC_INIT, rx_byte_i);
      end else if (p == PW'(1)) begin
        len_d = rx_byte_i;
        if (too_long) begin
          in_frame_d = 1'b0;
        end
      end else if (p == PW'(2)) begin
        cmd_d[15:8] = rx_byte_i;
      end else if (p == PW'(3)) begin
        cmd_d[7:0] = rx_byte_i;
      end else if (in_body) begin
        if (!off[0]) begin
          pend_d = rx_byte_i;
        end else begin
          ram_we = 1'b1;
        end
      end else if (is_check_hi) begin
        check_hi_d = rx_byte_i;
      end else begin
        in_frame_d = 1'b0;
      end
    end
  end

  // Argument counters for the emission of a good frame.
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (cmd_i.start_args) begin
      cnt_d = len_q[AW:1];
      idx_d = '0;
    end else if (cmd_i.load_arg) begin
      idx_d = idx_q + AW'(1);
    end
  end

  // Result register loading and release.
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    ocmd_d      = ocmd_q;
    ocnt_d      = ocnt_q;
    oidx_d      = oidx_q;
    oval_d      = oval_q;
    oargv_d     = oargv_q;
    olast_d     = olast_q;
    if (cmd_i.load_single) begin
      out_valid_d = 1'b1;
      status_d    = cmd_i.single_status;
      ocmd_d      = cmd_q;
      ocnt_d      = '0;
      oidx_d      = '0;
      oval_d      = '0;
      oargv_d     = 1'b0;
      olast_d     = 1'b1;
    end else if (cmd_i.load_arg) begin
      out_valid_d = 1'b1;
      status_d    = ccd_pkg::FS_GOOD;
      ocmd_d      = cmd_q;
      ocnt_d      = cnt_q;
      oidx_d      = idx_q;
      oval_d      = ram_rdata;
      oargv_d     = 1'b1;
      olast_d     = status_o.last_arg;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= ccd_pkg::HEADER_RESET;
      in_frame_q  <= 1'b0;
      pos_q       <= '0;
      len_q       <= '0;
      crc_q       <= ccd_pkg::CRC_INIT;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_wdata_i;
      end
      in_frame_q  <= in_frame_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    check_hi_q <= check_hi_d;
    pend_q     <= pend_d;
    status_q   <= status_d;
    ocmd_q     <= ocmd_d;
    ocnt_q     <= ocnt_d;
    oidx_q     <= oidx_d;
    oval_q     <= oval_d;
    oargv_q    <= oargv_d;
    olast_q    <= olast_d;
  end

  // Argument store.
  ccd_ram #(
    .WIDTH (16),
    .DEPTH (ccd_pkg::ARG_SLOTS)
  ) u_arg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({pend_q, rx_byte_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign frame_status_o   = status_q;
  assign command_code_o   = ocmd_q;
  assign argument_count_o = ocnt_q;
  assign argument_index_o = oidx_q;
  assign argument_value_o = oval_q;
  assign argument_valid_o = oargv_q;
  assign last_of_frame_o  = olast_q;

endmodule

// ===== hdl/ccd_controller.sv =====
// ----------------------------------------------------------------------------
// Command deframer controller
// Sequences byte intake and the emission of results at frame end.
// ----------------------------------------------------------------------------
module ccd_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  input  ccd_pkg::ccd_status_t status_i,
  output logic                 in_ready_o,
  output ccd_pkg::ccd_cmd_t    cmd_o
);

  ccd_pkg::ccd_state_e state_q, state_d;
  logic accept;
  logic can_load;

  // A final byte is only taken once the result register has room.
  assign in_ready_o = (state_q == ccd_pkg::ST_RUN)
                      && !(status_i.final_pending && status_i.out_full);
  assign accept     = in_valid_i && in_ready_o;
  assign can_load   = !status_i.out_full || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ccd_pkg::ST_RUN: begin
        if (accept && status_i.final_pending && status_i.crc_ok
            && !status_i.odd_len && !status_i.no_args) begin
          state_d = ccd_pkg::ST_READ;
        end
      end
      ccd_pkg::ST_READ: begin
        state_d = ccd_pkg::ST_SHOW;
      end
      ccd_pkg::ST_SHOW: begin
        if (can_load) begin
          state_d = status_i.last_arg ? ccd_pkg::ST_RUN : ccd_pkg::ST_READ;
        end
      end
      default: begin
        state_d = ccd_pkg::ST_RUN;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o               = '0;
    cmd_o.single_status = ccd_pkg::FS_GOOD;
    case (state_q)
      ccd_pkg::ST_RUN: begin
        cmd_o.accept = accept;
        if (accept && status_i.final_pending) begin
          if (!status_i.crc_ok) begin
            cmd_o.load_single   = 1'b1;
            cmd_o.single_status = ccd_pkg::FS_CRC_ERR;
          end else if (status_i.odd_len) begin
            cmd_o.load_single   = 1'b1;
            cmd_o.single_status = ccd_pkg::FS_ODD_LEN;
          end else if (status_i.no_args) begin
            cmd_o.load_single = 1'b1;
          end else begin
            cmd_o.start_args = 1'b1;
          end
        end
      end
      ccd_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ccd_pkg::ST_SHOW: begin
        cmd_o.load_arg = can_load;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccd_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/crc_checked_command_deframer.sv =====
// A result for an error or empty frame is registered in the cycle after the final CRC byte
// is taken; each argument of a good frame is read from the store, then loaded.
// Throughput: one byte per cycle while a frame is collected; input stalls while the
// controller reads the arguments of a good frame out of the argument store, and a final
// CRC byte waits while an earlier result is still held in the result register.
// Reset: asynchronous, active low; the block hunts for a header, which resets to 0xAA.
// ----------------------------------------------------------------------------
// CRC-checked command deframer
// Parses length-prefixed frames with a CRC-16 check and emits their arguments.
// ----------------------------------------------------------------------------
module crc_checked_command_deframer #(
  parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  ccd_rx_if.sink      rx_i,
  ccd_res_if.source   res_o
);

  ccd_pkg::ccd_cmd_t    cmd;
  ccd_pkg::ccd_status_t status;

  // Sequencing of intake and emission.
  ccd_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .in_ready_o  (rx_i.ready),
    .cmd_o       (cmd)
  );

  // Parsing, CRC and result storage.
  ccd_datapath #(
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_byte_i        (rx_i.rx_byte),
    .out_ready_i      (res_o.ready),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (res_o.valid),
    .frame_status_o   (res_o.frame_status),
    .command_code_o   (res_o.command_code),
    .argument_count_o (res_o.argument_count),
    .argument_index_o (res_o.argument_index),
    .argument_value_o (res_o.argument_value),
    .argument_valid_o (res_o.argument_valid),
    .last_of_frame_o  (res_o.last_of_frame)
  );

endmodule

// ===== hdl/ccd_checker.sv =====
// ----------------------------------------------------------------------------
// Command deframer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "crc_checked_command_deframer_macros.svh"

module ccd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  frame_status_i,
  input logic [15:0] command_code_i,
  input logic [4:0]  argument_count_i,
  input logic [4:0]  argument_index_i,
  input logic        argument_valid_i,
  input logic        last_of_frame_i
);

  // A waiting request keeps its command.
  property p_res_hold;
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(command_code_i);
  endproperty

  // An argument belongs to a good frame and lies inside its count.
  property p_arg_good;
    res_valid_i && argument_valid_i |->
      frame_status_i == ccd_pkg::FS_GOOD && argument_index_i < argument_count_i;
  endproperty

  // An argument is last exactly when its index closes the count.
  property p_arg_last;
    res_valid_i && argument_valid_i |->
      last_of_frame_i == (argument_index_i == argument_count_i - 5'd1);
  endproperty

  // An error result is a lone, final result without arguments.
  property p_err_lone;
    res_valid_i && frame_status_i != ccd_pkg::FS_GOOD |->
      last_of_frame_i && !argument_valid_i && argument_count_i == 5'd0;
  endproperty

  // No result is offered during reset.
  property p_rst_idle;
    !rst_ni |-> !res_valid_i;
  endproperty

  `CCD_ASSERT(a_res_hold, p_res_hold, "result dropped or changed while stalled")
  `CCD_ASSERT(a_arg_good, p_arg_good, "argument outside a good frame")
  `CCD_ASSERT(a_arg_last, p_arg_last, "last flag does not match argument index")
  `CCD_ASSERT(a_err_lone, p_err_lone, "error result carries arguments")
  `CCD_ASSERT_ALWAYS(a_rst_idle, p_rst_idle, "result valid during reset")

endmodule

bind crc_checked_command_deframer ccd_checker u_ccd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .frame_status_i   (res_o.frame_status),
  .command_code_i   (res_o.command_code),
  .argument_count_i (res_o.argument_count),
  .argument_index_i (res_o.argument_index),
  .argument_valid_i (res_o.argument_valid),
  .last_of_frame_i  (res_o.last_of_frame)
);
